[rtl/sas_pkg.sv]
package sas_pkg;

    localparam int DEF_MAX_BLOCKS = 16;
    localparam int DEF_MAX_STEPS  = 32;

    localparam int FRAME_W    = 8;
    localparam int DELAY_W    = 8;
    localparam int STEP_OUT_W = 8;
    localparam int BLK_OUT_W  = 4;
    localparam int FCOUNT_W   = 9;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [FCOUNT_W-1:0] FCOUNT_MAX         = 9'd256;
    localparam logic [DELAY_W-1:0]  FLIPBOOK_DELAY_RST = 8'd5;

    typedef enum logic [2:0] {
        KIND_TICK     = 3'd0,
        KIND_WR_ENTRY = 3'd1,
        KIND_WR_LEN   = 3'd2,
        KIND_RESTART  = 3'd3,
        KIND_PLACE    = 3'd4,
        KIND_HOLD     = 3'd5
    } t_kind;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_HOLD_LAST      = 3'd0,
        CFG_FRAME_COUNT    = 3'd1,
        CFG_ANIMATABLE     = 3'd2,
        CFG_DEFAULT_FRAME  = 3'd3,
        CFG_FLIPBOOK_DELAY = 3'd4
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_RD,
        ST_LOAD,
        ST_MOD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]         kind;
        logic [3:0]         block_sel;
        logic [4:0]         step_sel;
        logic [FRAME_W-1:0] frame_value;
        logic [DELAY_W-1:0] delay_value;
        logic [5:0]         block_length;
    } t_in;

    typedef struct packed {
        logic [FRAME_W-1:0]    current_frame;
        logic                  frame_changed;
        logic                  running;
        logic [BLK_OUT_W-1:0]  active_block;
        logic [STEP_OUT_W-1:0] active_step;
    } t_out;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [DELAY_W-1:0] delay;
    } t_entry;

    typedef struct packed {
        logic start;
        logic dn;
    } t_scan_cmd;

    typedef struct packed {
        logic done;
        logic found;
    } t_scan_sts;

endpackage

[rtl/sas_chan_if.sv]
interface sas_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/sas_tab.sv]
module sas_tab #(
    parameter int ADDR_W = 9
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_W-1:0]    i_waddr,
    input  sas_pkg::t_entry      i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_W-1:0]    i_raddr,
    output sas_pkg::t_entry      o_rdata
);

    sas_pkg::t_entry r_mem [2**ADDR_W];
    sas_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/sas_blk.sv]
module sas_blk #(
    parameter int MAX_BLOCKS = sas_pkg::DEF_MAX_BLOCKS,
    parameter int MAX_STEPS  = sas_pkg::DEF_MAX_STEPS,
    localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
    localparam int LW = $clog2(MAX_STEPS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [BW-1:0]         i_wblk,
    input  logic [LW-1:0]         i_wlen,
    input  logic [BW-1:0]         i_rblk,
    output logic [LW-1:0]         o_rlen,
    input  sas_pkg::t_scan_cmd    i_cmd,
    input  logic [BW-1:0]         i_from,
    output sas_pkg::t_scan_sts    o_sts,
    output logic [BW-1:0]         o_idx,
    output logic [LW-1:0]         o_len
);

    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [BW-1:0] LAST_BLK = BW'(MAX_BLOCKS - 1);

    logic [LW-1:0] r_len [MAX_BLOCKS];

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic          r_found, n_found;
    logic          r_dn, n_dn;
    logic [BW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [BW-1:0] r_res_idx, n_res_idx;
    logic [LW-1:0] r_res_len, n_res_len;

    logic [BW-1:0] rd_addr;
    logic [LW-1:0] rd_len;
    logic [BW-1:0] idx_step;

    assign rd_addr = r_busy ? r_idx : i_rblk;
    assign rd_len  = r_len[rd_addr];
    assign o_rlen  = rd_len;

    always_comb begin
        if (r_dn) begin
            idx_step = (r_idx == '0) ? LAST_BLK : r_idx - 1'b1;
        end else begin
            idx_step = (r_idx == LAST_BLK) ? '0 : r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < MAX_BLOCKS; b++) begin
                r_len[b] <= '0;
            end
        end else if (i_we) begin
            r_len[i_wblk] <= i_wlen;
        end
    end

    always_comb begin
        n_busy    = r_busy;
        n_done    = 1'b0;
        n_found   = r_found;
        n_dn      = r_dn;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_res_idx = r_res_idx;
        n_res_len = r_res_len;
        if (i_cmd.start) begin
            n_busy  = 1'b1;
            n_found = 1'b0;
            n_dn    = i_cmd.dn;
            n_idx   = i_from;
            n_cnt   = '0;
        end else if (r_busy) begin
            if (rd_len != '0) begin
                n_busy    = 1'b0;
                n_done    = 1'b1;
                n_found   = 1'b1;
                n_res_idx = r_idx;
                n_res_len = rd_len;
            end else if (r_cnt == CW'(MAX_BLOCKS - 1)) begin
                n_busy  = 1'b0;
                n_done  = 1'b1;
                n_found = 1'b0;
            end else begin
                n_idx = idx_step;
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dn      <= n_dn;
        r_idx     <= n_idx;
        r_cnt     <= n_cnt;
        r_res_idx <= n_res_idx;
        r_res_len <= n_res_len;
    end

    assign o_sts.done  = r_done;
    assign o_sts.found = r_found;
    assign o_idx       = r_res_idx;
    assign o_len       = r_res_len;

endmodule

[rtl/sas_mod.sv]
module sas_mod (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [sas_pkg::FRAME_W-1:0]    i_x,
    input  logic [sas_pkg::FCOUNT_W-1:0]   i_n,
    output logic                           o_done,
    output logic [sas_pkg::FRAME_W-1:0]    o_rem
);

    localparam int XW  = sas_pkg::FRAME_W;
    localparam int NW  = sas_pkg::FCOUNT_W;
    localparam int CNW = $clog2(XW);

    logic           r_busy, n_busy;
    logic           r_done, n_done;
    logic [CNW-1:0] r_cnt, n_cnt;
    logic [XW-1:0]  r_x, n_x;
    logic [XW-1:0]  r_rem, n_rem;
    logic [NW-1:0]  r_n, n_n;
    logic [XW:0]    trial;

    assign trial = {r_rem, r_x[XW-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_rem  = r_rem;
        n_n    = r_n;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_x    = i_x;
            n_rem  = '0;
            n_n    = i_n;
        end else if (r_busy) begin
            n_x   = r_x << 1;
            n_rem = (trial >= r_n) ? XW'(trial - r_n) : XW'(trial);
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNW'(XW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_x   <= n_x;
        r_rem <= n_rem;
        r_n   <= n_n;
    end

    assign o_done = r_done;
    assign o_rem  = (r_n == '0) ? '0 : r_rem;

endmodule

[rtl/sprite_animation_sequencer.sv]
// One transaction in flight; the next input is taken once the previous result is in the output
// register. Table writes, length writes, place frame and unused kinds go from execute straight to the
// result. Tick, restart and hold may also pass through the block-length scan (one block per cycle),
// the table read and the frame-count modulo (bit serial).
// Synchronous active-low reset clears block lengths, playback state and the configuration
// registers (flipbook delay to 5); the frame/delay table is not cleared.
module sprite_animation_sequencer #(
    parameter int MAX_BLOCKS = sas_pkg::DEF_MAX_BLOCKS,
    parameter int MAX_STEPS  = sas_pkg::DEF_MAX_STEPS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    sas_chan_if.sink                         i_in,
    sas_chan_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [sas_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [sas_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    localparam int BW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int SW  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int LW  = $clog2(MAX_STEPS + 1);
    localparam int AW  = BW + SW;
    localparam int FW  = sas_pkg::FRAME_W;
    localparam int DW  = sas_pkg::DELAY_W;
    localparam int NW  = sas_pkg::FCOUNT_W;
    localparam int PW  = sas_pkg::STEP_OUT_W;
    localparam int ABW = sas_pkg::BLK_OUT_W;
    localparam logic [BW-1:0] LAST_BLK = BW'(MAX_BLOCKS - 1);

    sas_pkg::t_state r_state, n_state;
    sas_pkg::t_in    r_in, n_in;
    logic [FW-1:0]   r_before, n_before;
    logic [BW-1:0]   r_cur_block, n_cur_block;
    logic [PW-1:0]   r_cur_step, n_cur_step;
    logic [DW-1:0]   r_delay, n_delay;
    logic [DW-1:0]   r_edelay, n_edelay;
    logic [FW-1:0]   r_shown, n_shown;
    logic            r_running, n_running;
    logic            r_seq, n_seq;
    logic            r_hold_mode, n_hold_mode;
    logic            r_out_valid, n_out_valid;
    sas_pkg::t_out   r_out, n_out;

    logic            r_hold_last;
    logic [NW-1:0]   r_fc;
    logic            r_animatable;
    logic [FW-1:0]   r_default;
    logic [DW-1:0]   r_fb_delay;

    logic            acc_in;
    logic            tab_we, tab_re;
    logic [AW-1:0]   tab_waddr, tab_raddr;
    sas_pkg::t_entry tab_wdata, tab_rdata;
    logic            blk_we;
    logic [LW-1:0]   blk_wlen;
    logic [BW-1:0]   blk_wsel;
    logic [LW-1:0]   rlen;
    sas_pkg::t_scan_cmd scan_cmd;
    logic [BW-1:0]   scan_from;
    sas_pkg::t_scan_sts scan_sts;
    logic [BW-1:0]   scan_idx;
    logic [LW-1:0]   scan_len;
    logic            mod_start, mod_done;
    logic [FW-1:0]   mod_rem;

    logic            blk_in_range, step_in_range;
    logic [NW-1:0]   step_inc, seq_pc;
    logic            seq_wrap, fb_wrap, fb_stop, fc_gt1, tick_early;
    logic [NW-1:0]   fb_step;
    logic [BW-1:0]   next_from;

    assign acc_in = i_in.valid && i_in.ready;

    assign blk_in_range  = int'(r_in.block_sel) < MAX_BLOCKS;
    assign step_in_range = int'(r_in.step_sel) < MAX_STEPS;
    assign step_inc      = {1'b0, r_cur_step} + 1'b1;
    assign seq_pc        = NW'(rlen);
    assign seq_wrap      = step_inc >= seq_pc;
    assign fc_gt1        = r_fc > NW'(1);
    assign fb_wrap       = step_inc >= r_fc;
    assign fb_stop       = fb_wrap && r_hold_mode;
    assign fb_step       = fb_wrap ? (r_hold_mode ? r_fc - 1'b1 : '0) : step_inc;
    assign tick_early    = !r_running || (r_delay > DW'(1));
    assign next_from     = (r_cur_block == LAST_BLK) ? '0 : r_cur_block + 1'b1;

    assign tab_waddr       = {BW'(r_in.block_sel), SW'(r_in.step_sel)};
    assign tab_raddr       = {r_cur_block, SW'(r_cur_step)};
    assign tab_wdata.frame = r_in.frame_value;
    assign tab_wdata.delay = r_in.delay_value;
    assign blk_wsel        = BW'(r_in.block_sel);
    assign blk_wlen        = (int'(r_in.block_length) > MAX_STEPS) ?
                             LW'(MAX_STEPS) : LW'(r_in.block_length);

    sas_tab #(
        .ADDR_W (AW)
    ) u_tab (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_re    (tab_re),
        .i_raddr (tab_raddr),
        .o_rdata (tab_rdata)
    );

    sas_blk #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .MAX_STEPS  (MAX_STEPS)
    ) u_blk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (blk_we),
        .i_wblk  (blk_wsel),
        .i_wlen  (blk_wlen),
        .i_rblk  (r_cur_block),
        .o_rlen  (rlen),
        .i_cmd   (scan_cmd),
        .i_from  (scan_from),
        .o_sts   (scan_sts),
        .o_idx   (scan_idx),
        .o_len   (scan_len)
    );

    sas_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_x     (tab_rdata.frame),
        .i_n     (r_fc),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_last  <= 1'b0;
            r_fc         <= '0;
            r_animatable <= 1'b0;
            r_default    <= '0;
            r_fb_delay   <= sas_pkg::FLIPBOOK_DELAY_RST;
        end else if (i_cfg_we) begin
            case (sas_pkg::t_cfg_reg'(i_cfg_addr))
                sas_pkg::CFG_HOLD_LAST: begin
                    r_hold_last <= i_cfg_wdata[0];
                end
                sas_pkg::CFG_FRAME_COUNT: begin
                    r_fc <= (i_cfg_wdata > sas_pkg::FCOUNT_MAX) ?
                            sas_pkg::FCOUNT_MAX : NW'(i_cfg_wdata);
                end
                sas_pkg::CFG_ANIMATABLE: begin
                    r_animatable <= i_cfg_wdata[0];
                end
                sas_pkg::CFG_DEFAULT_FRAME: begin
                    r_default <= i_cfg_wdata[FW-1:0];
                end
                sas_pkg::CFG_FLIPBOOK_DELAY: begin
                    r_fb_delay <= i_cfg_wdata[DW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sas_pkg::ST_IDLE: begin
                if (acc_in) n_state = sas_pkg::ST_EXEC;
            end
            sas_pkg::ST_EXEC: begin
                case (sas_pkg::t_kind'(r_in.kind))
                    sas_pkg::KIND_TICK: begin
                        if (tick_early || !r_seq || rlen == '0) begin
                            n_state = sas_pkg::ST_DONE;
                        end else if (seq_wrap && !r_hold_mode) begin
                            n_state = sas_pkg::ST_SCAN;
                        end else begin
                            n_state = sas_pkg::ST_RD;
                        end
                    end
                    sas_pkg::KIND_RESTART, sas_pkg::KIND_HOLD: begin
                        n_state = sas_pkg::ST_SCAN;
                    end
                    default: begin
                        n_state = sas_pkg::ST_DONE;
                    end
                endcase
            end
            sas_pkg::ST_SCAN: begin
                if (scan_sts.done) begin
                    if (scan_sts.found || r_in.kind == sas_pkg::KIND_TICK) begin
                        n_state = sas_pkg::ST_RD;
                    end else begin
                        n_state = sas_pkg::ST_DONE;
                    end
                end
            end
            sas_pkg::ST_RD: begin
                n_state = sas_pkg::ST_LOAD;
            end
            sas_pkg::ST_LOAD: begin
                n_state = sas_pkg::ST_MOD;
            end
            sas_pkg::ST_MOD: begin
                if (mod_done) n_state = sas_pkg::ST_DONE;
            end
            sas_pkg::ST_DONE: begin
                if (!r_out_valid || o_out.ready) n_state = sas_pkg::ST_IDLE;
            end
            default: begin
                n_state = sas_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and control
    always_comb begin
        n_in        = r_in;
        n_before    = r_before;
        n_cur_block = r_cur_block;
        n_cur_step  = r_cur_step;
        n_delay     = r_delay;
        n_edelay    = r_edelay;
        n_shown     = r_shown;
        n_running   = r_running;
        n_seq       = r_seq;
        n_hold_mode = r_hold_mode;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        tab_we      = 1'b0;
        tab_re      = 1'b0;
        blk_we      = 1'b0;
        scan_cmd    = '0;
        scan_from   = '0;
        mod_start   = 1'b0;

        case (r_state)
            sas_pkg::ST_IDLE: begin
                if (acc_in) begin
                    n_in     = i_in.payload;
                    n_before = r_shown;
                end
            end
            sas_pkg::ST_EXEC: begin
                case (sas_pkg::t_kind'(r_in.kind))
                    sas_pkg::KIND_TICK: begin
                        if (r_running) begin
                            if (r_delay > DW'(1)) begin
                                n_delay = r_delay - 1'b1;
                            end else begin
                                n_delay = '0;
                                if (r_seq) begin
                                    if (rlen == '0) begin
                                        n_running = 1'b0;
                                    end else if (seq_wrap) begin
                                        if (r_hold_mode) begin
                                            n_cur_step = PW'(seq_pc - 1'b1);
                                            n_running  = 1'b0;
                                        end else begin
                                            scan_cmd.start = 1'b1;
                                            scan_from      = next_from;
                                            n_cur_step     = '0;
                                        end
                                    end else begin
                                        n_cur_step = PW'(step_inc);
                                    end
                                end else if (!fc_gt1) begin
                                    n_running = 1'b0;
                                end else begin
                                    n_cur_step = PW'(fb_step);
                                    n_shown    = FW'(fb_step);
                                    if (fb_stop) begin
                                        n_running = 1'b0;
                                    end else begin
                                        n_delay = r_fb_delay;
                                    end
                                end
                            end
                        end
                    end
                    sas_pkg::KIND_WR_ENTRY: begin
                        tab_we = blk_in_range && step_in_range;
                    end
                    sas_pkg::KIND_WR_LEN: begin
                        blk_we = blk_in_range;
                    end
                    sas_pkg::KIND_RESTART: begin
                        n_hold_mode    = r_hold_last;
                        n_running      = r_animatable;
                        n_cur_step     = '0;
                        scan_cmd.start = 1'b1;
                        scan_from      = '0;
                    end
                    sas_pkg::KIND_PLACE: begin
                        n_running = 1'b0;
                        if ({1'b0, r_in.frame_value} < r_fc) begin
                            n_shown = r_in.frame_value;
                        end else if (r_fc != '0) begin
                            n_shown = '0;
                        end
                    end
                    sas_pkg::KIND_HOLD: begin
                        n_hold_mode    = 1'b1;
                        scan_cmd.start = 1'b1;
                        scan_cmd.dn    = 1'b1;
                        scan_from      = LAST_BLK;
                    end
                    default: begin
                    end
                endcase
            end
            sas_pkg::ST_SCAN: begin
                if (scan_sts.done) begin
                    case (sas_pkg::t_kind'(r_in.kind))
                        sas_pkg::KIND_TICK: begin
                            if (scan_sts.found) n_cur_block = scan_idx;
                        end
                        sas_pkg::KIND_RESTART: begin
                            if (scan_sts.found) begin
                                n_cur_block = scan_idx;
                                n_seq       = 1'b1;
                            end else begin
                                n_cur_block = LAST_BLK;
                                n_seq       = 1'b0;
                                n_shown     = r_default;
                                n_cur_step  = r_default;
                                n_delay     = r_fb_delay;
                            end
                        end
                        sas_pkg::KIND_HOLD: begin
                            if (scan_sts.found) begin
                                n_cur_block = scan_idx;
                                n_seq       = 1'b1;
                                n_cur_step  = PW'(scan_len - 1'b1);
                                n_delay     = '0;
                                n_running   = 1'b0;
                            end else begin
                                n_cur_block = LAST_BLK;
                                n_seq       = 1'b0;
                                n_cur_step  = r_default;
                                n_delay     = r_fb_delay;
                                if (fc_gt1) begin
                                    n_running = 1'b0;
                                    n_shown   = ({1'b0, r_default} < r_fc) ? r_default : '0;
                                end else begin
                                    n_running = r_animatable;
                                    n_shown   = r_default;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            sas_pkg::ST_RD: begin
                tab_re = 1'b1;
            end
            sas_pkg::ST_LOAD: begin
                mod_start = 1'b1;
                n_edelay  = tab_rdata.delay;
            end
            sas_pkg::ST_MOD: begin
                if (mod_done) begin
                    case (sas_pkg::t_kind'(r_in.kind))
                        sas_pkg::KIND_TICK: begin
                            if (r_running) n_delay = r_edelay;
                            if ({1'b0, mod_rem} < r_fc) n_shown = mod_rem;
                        end
                        sas_pkg::KIND_RESTART: begin
                            n_shown = mod_rem;
                            n_delay = r_edelay;
                        end
                        sas_pkg::KIND_HOLD: begin
                            n_shown = mod_rem;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            sas_pkg::ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid         = 1'b1;
                    n_out.current_frame = r_shown;
                    n_out.frame_changed = r_shown != r_before;
                    n_out.running       = r_running;
                    n_out.active_block  = ABW'(r_cur_block);
                    n_out.active_step   = r_cur_step;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sas_pkg::ST_IDLE;
            r_cur_block <= '0;
            r_cur_step  <= '0;
            r_delay     <= '0;
            r_shown     <= '0;
            r_running   <= 1'b0;
            r_seq       <= 1'b0;
            r_hold_mode <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_block <= n_cur_block;
            r_cur_step  <= n_cur_step;
            r_delay     <= n_delay;
            r_shown     <= n_shown;
            r_running   <= n_running;
            r_seq       <= n_seq;
            r_hold_mode <= n_hold_mode;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in     <= n_in;
        r_before <= n_before;
        r_edelay <= n_edelay;
        r_out    <= n_out;
    end

    assign i_in.ready    = (r_state == sas_pkg::ST_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    a_write_keeps_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sas_pkg::ST_DONE &&
         (r_in.kind == sas_pkg::KIND_WR_ENTRY || r_in.kind == sas_pkg::KIND_WR_LEN))
        |-> (r_shown == r_before))
        else $error("table write changed the shown frame");

    a_next_block_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sas_pkg::ST_SCAN && scan_sts.done && r_in.kind == sas_pkg::KIND_TICK)
        |-> scan_sts.found)
        else $error("next-block scan found no block");

    a_found_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (scan_sts.done && scan_sts.found) |-> (scan_len != '0))
        else $error("scan reported an empty block");

endmodule
